@@ design/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, sampled on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside of reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an expression is never true outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ design/mssd_pkg.sv @@
// -----------------------------------------------------------------------------
// Seven-segment driver package
// Types, constants and segment mapping functions shared by the driver modules.
// -----------------------------------------------------------------------------
`default_nettype none

package mssd_pkg;

  // Input command codes carried on the slave tuser bit.
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Drive word bases and reset values.
  localparam logic [15:0] HIGH_BASE  = 16'h0080;
  localparam logic [15:0] LOW_BASE   = 16'h0040;
  localparam logic [15:0] HIGH_RESET = 16'h8000;
  localparam logic [15:0] LOW_RESET  = 16'h4000;

  localparam int WORD_W     = 16;
  localparam int BCD_DIGITS = 5;
  localparam int PLACES     = 4;
  localparam int SEGMENTS   = 7;

  localparam logic [3:0] LAST_IDX = 4'd15;

  // Wiring of each place (thousands first) and segment (a first).
  // A positive entry k drives bit k-1 of the high word, a negative entry
  // drives bit -k-1 of the low word, and zero is an unwired segment.
  localparam logic signed [5:0] WIRE_MAP [PLACES][SEGMENTS] = '{
    '{6'sd0,   -6'sd3,  -6'sd4,  6'sd0,   6'sd0,   6'sd0,   6'sd0},
    '{-6'sd9,  -6'sd2,  -6'sd1,  6'sd1,   6'sd3,   6'sd9,   6'sd2},
    '{6'sd10,  6'sd11,  6'sd12,  -6'sd12, -6'sd13, -6'sd10, -6'sd11},
    '{-6'sd16, -6'sd14, -6'sd15, 6'sd15,  6'sd13,  6'sd16,  6'sd14}
  };

  // Front state machine.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COMPOSE
  } front_state_e;

  // One queued tick: the word to shift out and the phase it belongs to.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              phase;
  } tick_t;

  // Both drive words after a set.
  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } words_t;

  // Segment mask of a decimal digit, bit s standing for segment s.
  function automatic logic [SEGMENTS-1:0] glyph(input logic [3:0] dig);
    logic [SEGMENTS-1:0] g;
    case (dig)
      4'd0: g = 7'h3F;
      4'd1: g = 7'h06;
      4'd2: g = 7'h5B;
      4'd3: g = 7'h4F;
      4'd4: g = 7'h66;
      4'd5: g = 7'h6D;
      4'd6: g = 7'h7D;
      4'd7: g = 7'h07;
      4'd8: g = 7'h7F;
      4'd9: g = 7'h67;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Builds both drive words from the four shown digits and their blank flags.
  function automatic words_t compose_words(input logic [3:0] digs [PLACES],
                                           input logic [PLACES-1:0] shown);
    words_t              w;
    logic [SEGMENTS-1:0] g;
    int                  v;
    w.hi = HIGH_BASE;
    w.lo = LOW_BASE;
    for (int p = 0; p < PLACES; p++) begin
      g = glyph(digs[p]);
      for (int s = 0; s < SEGMENTS; s++) begin
        v = int'(WIRE_MAP[p][s]);
        if (shown[p] && g[s]) begin
          if (v > 0) begin
            w.hi[4'(v - 1)] = 1'b1;
          end else if (v < 0) begin
            w.lo[4'(-v - 1)] = 1'b1;
          end
        end
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/multiplexed_seven_segment_driver.sv @@
// -----------------------------------------------------------------------------
// Multiplexed seven-segment driver
// Four-place display driver that serializes two alternating 16-bit drive words.
// -----------------------------------------------------------------------------
// A set transfer (tuser = 0) loads the number in tdata; it is converted to
// decimal one bit per cycle, so the block is busy after a set is taken
// (16 conversion steps and a compose step to build the drive words) and
// a set yields no output. A tick transfer (tuser = 1) is taken while the
// front is idle and the tick queue has room (QUEUE_DEPTH entries) and yields
// 16 output transfers, one bit per cycle from the serializer unless the
// output stalls, bit 0 first, with tlast on bit 15 and tuser giving the
// phase (1 = high word). Consecutive ticks stream out with no gap. Ticks
// always use the words of the last completed set; the phase starts high
// after reset and toggles per tick.
`default_nettype none

module multiplexed_seven_segment_driver
  import mssd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // number[15:0]
  input  wire logic        s_axis_tuser_i,  // command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // data_bit, bit_index[3:0], zero pad
  output logic             m_axis_tuser_o,  // phase
  output logic             m_axis_tlast_o   // latch
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  tick_t q_in;
  tick_t q_out;

  // Command intake and word composition.
  mssd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_in)
  );

  // Pending ticks.
  mssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Bit serializer.
  mssd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_data_i        (q_out),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ design/mssd_front.sv @@
// -----------------------------------------------------------------------------
// Seven-segment driver front end
// Accepts set and tick commands, converts numbers to digits and drive words,
// and queues one word per tick for the serializer.
// -----------------------------------------------------------------------------
`default_nettype none

module mssd_front
  import mssd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // number[15:0]
  input  wire logic        s_axis_tuser_i,  // command
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output tick_t            q_data_o
);

  localparam int BCD_W = 4 * BCD_DIGITS;

  front_state_e state_q, state_d;

  logic [WORD_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  bcd_adj;
  logic [3:0]        cnt_q, cnt_d;
  logic [WORD_W-1:0] hi_q, hi_d;
  logic [WORD_W-1:0] lo_q, lo_d;
  logic              ph_q, ph_d;

  logic              accept;
  logic              is_tick;
  logic [3:0]        digs [PLACES];
  logic [PLACES-1:0] shown;
  words_t            words;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick = (s_axis_tuser_i == CMD_TICK);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_tick) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_COMPOSE;
        end
      end
      ST_COMPOSE: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    q_push_o        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = !q_full_i;
        q_push_o        = s_axis_tvalid_i && !q_full_i && is_tick;
      end
      default: begin
        s_axis_tready_o = 1'b0;
        q_push_o        = 1'b0;
      end
    endcase
  end

  assign q_data_o.word  = ph_q ? hi_q : lo_q;
  assign q_data_o.phase = ph_q;

  // Shift-and-add-three step of the binary to decimal conversion.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Digits as shown: a thousands count above one blanks that place, and
  // leading zeros blank until the first nonzero digit.
  always_comb begin
    digs[0] = ((bcd_q[19:16] == 4'd0) && (bcd_q[15:12] == 4'd1)) ? 4'd1 : 4'd0;
    digs[1] = bcd_q[11:8];
    digs[2] = bcd_q[7:4];
    digs[3] = bcd_q[3:0];
    shown[0] = (digs[0] != 4'd0);
    shown[1] = shown[0] || (digs[1] != 4'd0);
    shown[2] = shown[1] || (digs[2] != 4'd0);
    shown[3] = 1'b1;
    words    = compose_words(digs, shown);
  end

  // Datapath next values.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    ph_d  = ph_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_tick) begin
          bin_d = s_axis_tdata_i;
          bcd_d = '0;
          cnt_d = '0;
        end else if (q_push_o) begin
          ph_d = !ph_q;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[WORD_W-1]};
        bin_d = {bin_q[WORD_W-2:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
      end
      ST_COMPOSE: begin
        hi_d = words.hi;
        lo_d = words.lo;
      end
      default: begin
        bin_d = bin_q;
      end
    endcase
  end

  // Control and drive-word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      hi_q    <= HIGH_RESET;
      lo_q    <= LOW_RESET;
      ph_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      ph_q    <= ph_d;
    end
  end

  // Conversion working registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

@@ design/mssd_queue.sv @@
// -----------------------------------------------------------------------------
// Seven-segment driver tick queue
// Small first-in first-out buffer of pending words between front and back.
// -----------------------------------------------------------------------------
`default_nettype none

module mssd_queue
  import mssd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire tick_t push_data_i,
  input  wire logic  pop_i,
  output tick_t      pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tick_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full tick queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from an empty tick queue")
  `ASSERT_AT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "tick queue count out of range")

endmodule

`default_nettype wire

@@ design/mssd_back.sv @@
// -----------------------------------------------------------------------------
// Seven-segment driver serializer
// Shifts each queued word out one bit per transfer, least significant first.
// -----------------------------------------------------------------------------
`default_nettype none

module mssd_back
  import mssd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tick_t      q_data_i,
  input  wire logic       q_empty_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // data_bit, bit_index[3:0], zero pad
  output logic            m_axis_tuser_o,  // phase
  output logic            m_axis_tlast_o   // latch
);

  `include "assert_macros.svh"

  logic              valid_q;
  logic [3:0]        idx_q;
  logic              bit_q;
  logic              ph_q;
  logic [WORD_W-1:0] word_q;
  logic              advance;
  logic              mid_word;

  assign advance  = !valid_q || m_axis_tready_i;
  assign mid_word = valid_q && (idx_q != LAST_IDX);
  assign q_pop_o  = advance && !mid_word && !q_empty_i;

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {3'b000, idx_q, bit_q};
  assign m_axis_tuser_o  = ph_q;
  assign m_axis_tlast_o  = (idx_q == LAST_IDX);

  // Output stage: next bit of the current word, or the first bit of the next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (advance) begin
      if (mid_word) begin
        idx_q <= idx_q + 4'd1;
      end else if (!q_empty_i) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (mid_word) begin
        bit_q <= word_q[idx_q + 4'd1];
      end else if (!q_empty_i) begin
        word_q <= q_data_i.word;
        ph_q   <= q_data_i.phase;
        bit_q  <= q_data_i.word[0];
      end
    end
  end

  `ASSERT_AT(a_step_bit, mid_word && m_axis_tready_i |=> valid_q && (idx_q == $past(idx_q) + 4'd1), "serializer skipped a bit")
  `ASSERT_AT(a_new_word, valid_q && m_axis_tready_i && (idx_q == LAST_IDX) |=> !valid_q || (idx_q == 4'd0), "word did not start at bit zero")
  `ASSERT_AT(a_pop_gap, q_pop_o |-> !valid_q || (m_axis_tready_i && idx_q == LAST_IDX), "word taken while another is in flight")

endmodule

`default_nettype wire
